// ===== design/assert_macros.svh =====
// Assertion helpers used by the line rasterizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every rising clock edge, ignored while reset is asserted.
`define DSL_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error(msg);

// Checked at every rising clock edge, reset included.
`define DSL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) \
	else $error(msg);

`else

`define DSL_ASSERT(lbl, clk, rst_n, prop, msg)
`define DSL_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== design/dsl_pkg.sv =====
package dsl_pkg;

	localparam int COORD_BITS = 12;
	localparam int DEC_BITS   = COORD_BITS + 4;
	localparam int REM_BITS   = COORD_BITS + 1;

	typedef logic [COORD_BITS-1:0]        coord_t;
	typedef logic signed [DEC_BITS-1:0]   dec_t;
	typedef logic [REM_BITS-1:0]          rem_t;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} cmd_e;

	typedef struct packed {
		coord_t first_px;
		coord_t first_py;
		coord_t second_px;
		coord_t second_py;
		logic   second_valid;
		logic   last;
	} res_t;

endpackage

// ===== design/dsl_in_if.sv =====
interface dsl_in_if;
	import dsl_pkg::*;

	logic   valid;
	logic   ready;
	cmd_e   command;
	coord_t start_x;
	coord_t start_y;
	coord_t end_x;
	coord_t end_y;

	modport source (
		output valid, command, start_x, start_y, end_x, end_y,
		input  ready
	);

	modport sink (
		input  valid, command, start_x, start_y, end_x, end_y,
		output ready
	);

endinterface

// ===== design/dsl_out_if.sv =====
interface dsl_out_if;
	import dsl_pkg::*;

	logic   valid;
	logic   ready;
	coord_t first_px;
	coord_t first_py;
	coord_t second_px;
	coord_t second_py;
	logic   second_valid;
	logic   last;

	modport source (
		output valid, first_px, first_py, second_px, second_py, second_valid, last,
		input  ready
	);

	modport sink (
		input  valid, first_px, first_py, second_px, second_py, second_valid, last,
		output ready
	);

endinterface

// ===== design/double_step_line_rasterizer.sv =====
// Double-step line rasterizer. A start item (command = 0) loads two endpoints
// and sets up the line; each step item (command = 1) then yields the next two
// pixels along the major axis, the start pixel itself never being issued. The
// final step of a line with an odd pixel count carries one pixel only
// (second_valid = 0, second pixel zero), and the item that reaches the end
// point has last = 1. Start items and steps sent with no line in progress give
// no result; a start replaces any line in progress. Throughput is one item per
// clock while req.ready is high: the setup and the pixel-pair step are each a
// single pass of add, compare and select logic on the line registers. A result
// is on the output in the cycle after its step item is taken when the result
// register is empty or being read in that cycle; otherwise it waits in a
// one-entry skid buffer until the sink takes the result ahead of it. req.ready
// falls only while both hold results that the sink has not yet taken.
`include "assert_macros.svh"

module double_step_line_rasterizer (
	input  logic      clk,
	input  logic      arst_n,
	dsl_in_if.sink    req,
	dsl_out_if.source rsp
);
	import dsl_pkg::*;

	function automatic coord_t step_coord(input coord_t v, input logic neg);
		return neg ? coord_t'(v - coord_t'(1)) : coord_t'(v + coord_t'(1));
	endfunction

	// line state
	coord_t cur_x_q, cur_y_q;
	logic   dir_x_neg_q, dir_y_neg_q;
	logic   x_major_q, steep_q;
	dec_t   decision_q, inc_one_q, inc_two_q, split_q;
	rem_t   remaining_q;
	logic   active_q;

	// output side
	logic out_v_q, skid_v_q;
	res_t out_q, skid_q;

	logic req_fire, start_fire, res_gen, out_take, out_free;

	assign req.ready  = !skid_v_q;
	assign req_fire   = req.valid && req.ready;
	assign start_fire = req_fire && (req.command == CMD_START);
	assign res_gen    = req_fire && (req.command == CMD_STEP) && active_q;
	assign out_take   = out_v_q && rsp.ready;
	assign out_free   = !out_v_q || out_take;

	// ---------------- line setup ----------------
	logic signed [COORD_BITS:0] dx_w, dy_w, adx_w, ady_w;
	coord_t adx, ady, big_w, small_w;
	logic   x_major_w, steep_w;
	dec_t   big_d, small_d, diff_d, inc_two_w, inc_one_w, split_w, decision_w;

	always_comb begin
		dx_w      = $signed({1'b0, req.end_x}) - $signed({1'b0, req.start_x});
		dy_w      = $signed({1'b0, req.end_y}) - $signed({1'b0, req.start_y});
		adx_w     = dx_w[COORD_BITS] ? -dx_w : dx_w;
		ady_w     = dy_w[COORD_BITS] ? -dy_w : dy_w;
		adx       = adx_w[COORD_BITS-1:0];
		ady       = ady_w[COORD_BITS-1:0];
		x_major_w = adx > ady;
		big_w     = x_major_w ? adx : ady;
		small_w   = x_major_w ? ady : adx;
		big_d     = $signed({{(DEC_BITS-COORD_BITS){1'b0}}, big_w});
		small_d   = $signed({{(DEC_BITS-COORD_BITS){1'b0}}, small_w});
		diff_d    = small_d - big_d;
		inc_two_w = (small_d <<< 2) - (big_d <<< 1);
		steep_w   = !inc_two_w[DEC_BITS-1];
		if (steep_w) begin
			split_w    = diff_d <<< 1;
			inc_one_w  = diff_d <<< 2;
			decision_w = (diff_d <<< 2) + big_d;
		end else begin
			split_w    = small_d <<< 1;
			inc_one_w  = small_d <<< 2;
			decision_w = (small_d <<< 2) - big_d;
		end
	end

	// ---------------- pixel pair step ----------------
	logic   use_one, first_diag, second_diag, rem_ge2, active_nxt;
	coord_t p1x, p1y, p2x, p2y;
	dec_t   decision_nxt;
	rem_t   rem_nxt;
	res_t   res_w;

	always_comb begin
		if (!steep_q ? decision_q[DEC_BITS-1] : (decision_q > dec_t'(0))) begin
			use_one     = 1'b1;
			first_diag  = steep_q;
			second_diag = steep_q;
		end else begin
			use_one     = 1'b0;
			first_diag  = !(decision_q < split_q);
			second_diag = decision_q < split_q;
		end
		p1x = (x_major_q || first_diag)  ? step_coord(cur_x_q, dir_x_neg_q) : cur_x_q;
		p1y = (!x_major_q || first_diag) ? step_coord(cur_y_q, dir_y_neg_q) : cur_y_q;
		p2x = (x_major_q || second_diag)  ? step_coord(p1x, dir_x_neg_q) : p1x;
		p2y = (!x_major_q || second_diag) ? step_coord(p1y, dir_y_neg_q) : p1y;

		rem_ge2      = remaining_q > rem_t'(1);
		rem_nxt      = rem_ge2 ? rem_t'(remaining_q - rem_t'(2)) : '0;
		active_nxt   = rem_nxt != '0;
		decision_nxt = decision_q + (use_one ? inc_one_q : inc_two_q);

		res_w.first_px     = p1x;
		res_w.first_py     = p1y;
		res_w.second_px    = rem_ge2 ? p2x : '0;
		res_w.second_py    = rem_ge2 ? p2y : '0;
		res_w.second_valid = rem_ge2;
		res_w.last         = !active_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			dir_x_neg_q <= 1'b0;
			dir_y_neg_q <= 1'b0;
			x_major_q   <= 1'b0;
			steep_q     <= 1'b0;
			decision_q  <= '0;
			inc_one_q   <= '0;
			inc_two_q   <= '0;
			split_q     <= '0;
			remaining_q <= '0;
			active_q    <= 1'b0;
		end else if (start_fire) begin
			cur_x_q     <= req.start_x;
			cur_y_q     <= req.start_y;
			dir_x_neg_q <= dx_w[COORD_BITS];
			dir_y_neg_q <= dy_w[COORD_BITS];
			x_major_q   <= x_major_w;
			steep_q     <= steep_w;
			decision_q  <= decision_w;
			inc_one_q   <= inc_one_w;
			inc_two_q   <= inc_two_w;
			split_q     <= split_w;
			remaining_q <= {1'b0, big_w};
			active_q    <= big_w != '0;
		end else if (res_gen) begin
			cur_x_q     <= rem_ge2 ? p2x : p1x;
			cur_y_q     <= rem_ge2 ? p2y : p1y;
			decision_q  <= decision_nxt;
			remaining_q <= rem_nxt;
			active_q    <= active_nxt;
		end
	end

	// ---------------- result register and skid ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q  <= skid_v_q || res_gen;
			skid_v_q <= skid_v_q && res_gen;
		end else if (res_gen) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_v_q) begin
				out_q <= skid_q;
				if (res_gen)
					skid_q <= res_w;
			end else if (res_gen) begin
				out_q <= res_w;
			end
		end else if (res_gen) begin
			skid_q <= res_w;
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.first_px     = out_q.first_px;
	assign rsp.first_py     = out_q.first_py;
	assign rsp.second_px    = out_q.second_px;
	assign rsp.second_py    = out_q.second_py;
	assign rsp.second_valid = out_q.second_valid;
	assign rsp.last         = out_q.last;

	`DSL_ASSERT(a_skid_behind_out, clk, arst_n, skid_v_q |-> out_v_q,
		"skid full with output empty")
	`DSL_ASSERT(a_active_has_rem, clk, arst_n, active_q |-> (remaining_q != '0),
		"active line with no pixels left")
	`DSL_ASSERT(a_rem_by_two, clk, arst_n,
		(res_gen && rem_ge2) |=> (remaining_q == rem_t'($past(remaining_q) - rem_t'(2))),
		"pixel count not reduced by two")
	`DSL_ASSERT(a_start_loads, clk, arst_n,
		start_fire |=> (cur_x_q == $past(req.start_x) && cur_y_q == $past(req.start_y)),
		"start point not loaded")

endmodule
